// ----- design/ufrb_pkg.sv -----
package ufrb_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int STACK_DEPTH = 2048;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int SIZE_W   = NODE_W + 1;
    localparam int FILL_W   = $clog2(STACK_DEPTH + 1);
    localparam int SADDR_W  = $clog2(STACK_DEPTH);
    localparam int COUNT_W  = 10;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 10'd1023;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_JOIN     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROLLBACK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_MERGED  = 3'd0,
        ST_SAME    = 3'd1,
        ST_UNDONE  = 3'd2,
        ST_MARKER  = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_FULL    = 3'd5,
        ST_BAD     = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

    // Packed so that the first field sits in the highest bits.
    typedef struct packed {
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_a;
        logic [CMD_W-1:0]  command;
    } cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0]  root;
        logic [COUNT_W-1:0] components;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [NODE_W-1:0] parent;
    } node_word_t;

    typedef struct packed {
        logic              marker;
        logic [NODE_W-1:0] child;
    } stack_entry_t;

    localparam int NODE_WORD_W = $bits(node_word_t);
    localparam int STACK_W     = $bits(stack_entry_t);
    localparam int IN_FIELD_W  = $bits(cmd_t);
    localparam int OUT_FIELD_W = $bits(result_t);
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

// ----- design/ufrb_ram.sv -----
module ufrb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 21
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // A read at the address being written returns the old word.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ufrb_ctrl.sv -----
module ufrb_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ufrb_pkg::cmd_t                      in_cmd,
    input  logic [ufrb_pkg::COUNT_W-1:0]        node_count,
    output logic                                res_valid,
    input  logic                                res_ready,
    output ufrb_pkg::result_t                   res,
    output logic                                node_we,
    output logic [ufrb_pkg::NODE_W-1:0]         node_waddr,
    output logic [ufrb_pkg::NODE_WORD_W-1:0]    node_wdata,
    output logic [ufrb_pkg::NODE_W-1:0]         node_raddr,
    input  logic [ufrb_pkg::NODE_WORD_W-1:0]    node_rdata,
    output logic                                stack_we,
    output logic [ufrb_pkg::SADDR_W-1:0]        stack_waddr,
    output logic [ufrb_pkg::STACK_W-1:0]        stack_wdata,
    output logic [ufrb_pkg::SADDR_W-1:0]        stack_raddr,
    input  logic [ufrb_pkg::STACK_W-1:0]        stack_rdata
);

    import ufrb_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DECODE,
        S_WALK_A,
        S_WALK_B,
        S_SZ_A,
        S_SZ_B,
        S_MERGE,
        S_POP,
        S_UNDO1,
        S_UNDO2,
        S_UNDO3,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [NODE_W-1:0]   x_reg, x_next;
    logic [NODE_W-1:0]   step_reg, step_next;
    logic [NODE_W-1:0]   ra_reg, ra_next;
    logic [NODE_W-1:0]   rb_reg, rb_next;
    logic [NODE_W-1:0]   pa_reg, pa_next;
    logic [SIZE_W-1:0]   sa_reg, sa_next;
    logic [NODE_W-1:0]   child_reg, child_next;
    logic [SIZE_W-1:0]   sum_reg, sum_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [COUNT_W-1:0]  comp_reg, comp_next;
    logic [NODE_W-1:0]   sweep_idx_reg, sweep_idx_next;
    logic [NODE_W-1:0]   sweep_last_reg, sweep_last_next;
    logic                sweep_clear_reg, sweep_clear_next;
    status_t             status_reg, status_next;
    logic [NODE_W-1:0]   root_reg, root_next;

    node_word_t          nrd;
    node_word_t          nwr;
    stack_entry_t        srd;
    stack_entry_t        swr;
    logic [FILL_W-1:0]   fill_dec;
    logic [FILL_W-1:0]   fill_inc;
    logic                walk_hit;
    logic                walk_end;
    logic [NODE_W-1:0]   walk_root;
    logic [SIZE_W-1:0]   size_diff;
    logic [COUNT_W-1:0]  comp_dec;
    logic [COUNT_W-1:0]  comp_inc;

    assign nrd        = node_word_t'(node_rdata);
    assign srd        = stack_entry_t'(stack_rdata);
    assign node_wdata = nwr;
    assign stack_wdata = swr;

    assign fill_dec  = fill_reg - FILL_W'(1);
    assign fill_inc  = fill_reg + FILL_W'(1);
    assign comp_dec  = (comp_reg == '0) ? comp_reg : comp_reg - COUNT_W'(1);
    assign comp_inc  = (comp_reg == COUNT_MAX) ? comp_reg : comp_reg + COUNT_W'(1);
    assign size_diff = nrd.size - sa_reg;

    // A walk ends at a self link, or after the longest chain the table can hold.
    assign walk_hit  = (nrd.parent == x_reg);
    assign walk_end  = walk_hit || (step_reg == NODE_W'(MAX_NODES - 1));
    assign walk_root = walk_hit ? x_reg : nrd.parent;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res.status     = status_reg;
    assign res.components = comp_reg;
    assign res.root       = root_reg;

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        x_next           = x_reg;
        step_next        = step_reg;
        ra_next          = ra_reg;
        rb_next          = rb_reg;
        pa_next          = pa_reg;
        sa_next          = sa_reg;
        child_next       = child_reg;
        sum_next         = sum_reg;
        fill_next        = fill_reg;
        comp_next        = comp_reg;
        sweep_idx_next   = sweep_idx_reg;
        sweep_last_next  = sweep_last_reg;
        sweep_clear_next = sweep_clear_reg;
        status_next      = status_reg;
        root_next        = root_reg;

        node_we     = 1'b0;
        node_waddr  = x_reg;
        nwr         = '0;
        node_raddr  = x_reg;
        stack_we    = 1'b0;
        stack_waddr = fill_reg[SADDR_W-1:0];
        swr         = '0;
        stack_raddr = fill_dec[SADDR_W-1:0];

        case (state_reg)
            S_SWEEP: begin
                node_we    = 1'b1;
                node_waddr = sweep_idx_reg;
                nwr.parent = sweep_idx_reg;
                nwr.size   = SIZE_W'(1);
                if (sweep_idx_reg == sweep_last_reg) begin
                    if (sweep_clear_reg) begin
                        status_next = ST_CLEARED;
                        root_next   = '0;
                        state_next  = S_FINISH;
                    end else begin
                        state_next  = S_IDLE;
                    end
                end else begin
                    sweep_idx_next = sweep_idx_reg + NODE_W'(1);
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                root_next = '0;
                case (cmd_reg.command)
                    CMD_JOIN: begin
                        if (cmd_reg.node_a > node_count || cmd_reg.node_b > node_count) begin
                            status_next = ST_BAD;
                            state_next  = S_FINISH;
                        end else if (fill_reg == FILL_W'(STACK_DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end else begin
                            node_raddr = cmd_reg.node_a;
                            x_next     = cmd_reg.node_a;
                            step_next  = '0;
                            state_next = S_WALK_A;
                        end
                    end
                    CMD_ROLLBACK: begin
                        if (fill_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end else begin
                            fill_next  = fill_dec;
                            state_next = S_POP;
                        end
                    end
                    CMD_CLEAR: begin
                        sweep_idx_next = '0;
                        if (node_count > COUNT_W'(MAX_NODES - 1)) begin
                            sweep_last_next = NODE_W'(MAX_NODES - 1);
                        end else begin
                            sweep_last_next = NODE_W'(node_count);
                        end
                        sweep_clear_next = 1'b1;
                        fill_next        = '0;
                        comp_next        = node_count;
                        state_next       = S_SWEEP;
                    end
                    default: begin
                        status_next = ST_BAD;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_WALK_A: begin
                if (walk_end) begin
                    ra_next    = walk_root;
                    x_next     = cmd_reg.node_b;
                    step_next  = '0;
                    node_raddr = cmd_reg.node_b;
                    state_next = S_WALK_B;
                end else begin
                    x_next     = nrd.parent;
                    step_next  = step_reg + NODE_W'(1);
                    node_raddr = nrd.parent;
                end
            end
            S_WALK_B: begin
                if (walk_end) begin
                    rb_next = walk_root;
                    if (walk_root == ra_reg) begin
                        stack_we    = 1'b1;
                        swr.marker  = 1'b1;
                        fill_next   = fill_inc;
                        status_next = ST_SAME;
                        root_next   = ra_reg;
                        state_next  = S_FINISH;
                    end else begin
                        node_raddr = ra_reg;
                        state_next = S_SZ_A;
                    end
                end else begin
                    x_next     = nrd.parent;
                    step_next  = step_reg + NODE_W'(1);
                    node_raddr = nrd.parent;
                end
            end
            S_SZ_A: begin
                pa_next    = nrd.parent;
                sa_next    = nrd.size;
                node_raddr = rb_reg;
                state_next = S_SZ_B;
            end
            S_SZ_B: begin
                // On equal sizes the root of node_a survives.
                node_we = 1'b1;
                if (sa_reg < nrd.size) begin
                    node_waddr = ra_reg;
                    nwr.parent = rb_reg;
                    nwr.size   = sa_reg;
                    ra_next    = rb_reg;
                    pa_next    = nrd.parent;
                    child_next = ra_reg;
                end else begin
                    node_waddr = rb_reg;
                    nwr.parent = ra_reg;
                    nwr.size   = nrd.size;
                    child_next = rb_reg;
                end
                sum_next   = sa_reg + nrd.size;
                state_next = S_MERGE;
            end
            S_MERGE: begin
                node_we     = 1'b1;
                node_waddr  = ra_reg;
                nwr.parent  = pa_reg;
                nwr.size    = sum_reg;
                stack_we    = 1'b1;
                swr.marker  = 1'b0;
                swr.child   = child_reg;
                fill_next   = fill_inc;
                comp_next   = comp_dec;
                status_next = ST_MERGED;
                root_next   = ra_reg;
                state_next  = S_FINISH;
            end
            S_POP: begin
                if (srd.marker) begin
                    status_next = ST_MARKER;
                    state_next  = S_FINISH;
                end else begin
                    child_next = srd.child;
                    node_raddr = srd.child;
                    state_next = S_UNDO1;
                end
            end
            S_UNDO1: begin
                pa_next    = nrd.parent;
                sa_next    = nrd.size;
                node_raddr = nrd.parent;
                state_next = S_UNDO2;
            end
            S_UNDO2: begin
                node_we    = 1'b1;
                node_waddr = pa_reg;
                nwr.parent = nrd.parent;
                nwr.size   = size_diff;
                // A child that is its own parent keeps the reduced size.
                sum_next   = (pa_reg == child_reg) ? size_diff : sa_reg;
                state_next = S_UNDO3;
            end
            S_UNDO3: begin
                node_we     = 1'b1;
                node_waddr  = child_reg;
                nwr.parent  = child_reg;
                nwr.size    = sum_reg;
                comp_next   = comp_inc;
                status_next = ST_UNDONE;
                root_next   = child_reg;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_SWEEP;
            fill_reg        <= '0;
            comp_reg        <= NODE_COUNT_RESET;
            sweep_idx_reg   <= '0;
            sweep_last_reg  <= NODE_W'(MAX_NODES - 1);
            sweep_clear_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            comp_reg        <= comp_next;
            sweep_idx_reg   <= sweep_idx_next;
            sweep_last_reg  <= sweep_last_next;
            sweep_clear_reg <= sweep_clear_next;
        end
        cmd_reg    <= cmd_next;
        x_reg      <= x_next;
        step_reg   <= step_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        pa_reg     <= pa_next;
        sa_reg     <= sa_next;
        child_reg  <= child_next;
        sum_reg    <= sum_next;
        status_reg <= status_next;
        root_reg   <= root_next;
    end

`ifndef SYNTH
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == S_DECODE)
        else $error("accepted word did not move to decode");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_no_write_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        node_we |-> state_reg != S_IDLE && state_reg != S_FINISH)
        else $error("node table written while idle or waiting");

    a_merge_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MERGE |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("merge did not push the undo stack");
`endif

endmodule

// ----- design/union_find_with_rollback_unit.sv -----
// Disjoint-set table with undo, union by size, no path compression. After reset the
// node table is swept to singletons, one node a cycle, with s_tready low; cfg writes
// are taken at any time. A join walks the parent links from node_a and node_b; the
// node table memory is read once per link, so the chain lengths (at most about log2
// of the node count with union by size) set the time. A clear sweeps nodes
// 0..node_count through the node table. One result word comes out for each command
// word, in order; a finished result waits in the output register while the next
// command word is taken.
module union_find_with_rollback_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // command [1:0], node_a [11:2], node_b [21:12], zero fill above
    input  logic [ufrb_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [2:0], components [12:3], root [22:13], zero fill above
    output logic [ufrb_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ufrb_pkg::COUNT_W-1:0]        cfg_data
);

    import ufrb_pkg::*;

    logic [COUNT_W-1:0]     node_count_reg, node_count_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    cmd_t                   in_cmd;
    result_t                res;
    logic                   res_valid;
    logic                   res_ready;

    logic                   node_we;
    logic [NODE_W-1:0]      node_waddr;
    logic [NODE_WORD_W-1:0] node_wdata;
    logic [NODE_W-1:0]      node_raddr;
    logic [NODE_WORD_W-1:0] node_rdata;
    logic                   stack_we;
    logic [SADDR_W-1:0]     stack_waddr;
    logic [STACK_W-1:0]     stack_wdata;
    logic [SADDR_W-1:0]     stack_raddr;
    logic [STACK_W-1:0]     stack_rdata;

    assign in_cmd    = cmd_t'(s_tdata[IN_FIELD_W-1:0]);
    assign cfg_ready = 1'b1;
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        node_count_next = node_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        if (cfg_valid) begin
            node_count_next = cfg_data;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_DATA_W'(res);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            node_count_reg <= node_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    ufrb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (in_cmd),
        .node_count  (node_count_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .node_we     (node_we),
        .node_waddr  (node_waddr),
        .node_wdata  (node_wdata),
        .node_raddr  (node_raddr),
        .node_rdata  (node_rdata),
        .stack_we    (stack_we),
        .stack_waddr (stack_waddr),
        .stack_wdata (stack_wdata),
        .stack_raddr (stack_raddr),
        .stack_rdata (stack_rdata)
    );

    // Parent link and tree size of each node share one word.
    ufrb_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (NODE_WORD_W)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    ufrb_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (STACK_W)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

endmodule
